// ----- src/kli_pkg.sv -----
// shared constants and types for the keyframe interpolator
`timescale 1ns / 1ps
package kli_pkg;

    localparam int KLI_W            = 32;
    localparam int STEP_W           = 16;
    localparam int DEF_CHANNELS     = 22;
    localparam int DEF_MAX_KEYS     = 64;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd750;

    localparam logic [1:0] CMD_STORE  = 2'd0;
    localparam logic [1:0] CMD_TOGGLE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_NEXT,
        ST_RD_CUR,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ADD_GO,
        ST_ADD_WAIT,
        ST_WRITE
    } kli_state_t;

    typedef enum logic [1:0] {
        MODE_LOAD,
        MODE_ADVANCE,
        MODE_ADD,
        MODE_REPORT
    } kli_mode_t;

endpackage

// ----- src/kli_serial_add.sv -----
// bit-serial saturating adder, one bit per cycle
`timescale 1ns / 1ps
module kli_serial_add (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [kli_pkg::KLI_W-1:0]        a,
    input  logic signed [kli_pkg::KLI_W-1:0]        b,
    output logic signed [kli_pkg::KLI_W-1:0]        sum,
    output logic                                    done
);
    import kli_pkg::*;

    localparam int CNTW = $clog2(KLI_W);

    logic [KLI_W-1:0] a_sh_reg;
    logic [KLI_W-1:0] b_sh_reg;
    logic [KLI_W-1:0] s_sh_reg;
    logic             carry_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [KLI_W-1:0] sum_reg;

    logic             s_bit;
    logic             c_next;
    logic [KLI_W-1:0] raw;

    assign s_bit  = a_sh_reg[0] ^ b_sh_reg[0] ^ carry_reg;
    assign c_next = (a_sh_reg[0] & b_sh_reg[0]) | (carry_reg & (a_sh_reg[0] ^ b_sh_reg[0]));
    assign raw    = {s_bit, s_sh_reg[KLI_W-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(KLI_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sh_reg  <= a;
            b_sh_reg  <= b;
            carry_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            a_sh_reg  <= {1'b0, a_sh_reg[KLI_W-1:1]};
            b_sh_reg  <= {1'b0, b_sh_reg[KLI_W-1:1]};
            s_sh_reg  <= raw;
            carry_reg <= c_next;
            if (cnt_reg == CNTW'(KLI_W - 1))
            begin
                // sign bits are the last ones shifted in
                if ((a_sh_reg[0] == b_sh_reg[0]) && (s_bit != a_sh_reg[0]))
                    sum_reg <= a_sh_reg[0] ? {1'b1, {(KLI_W-1){1'b0}}}
                                           : {1'b0, {(KLI_W-1){1'b1}}};
                else
                    sum_reg <= raw;
            end
        end
    end

    assign sum  = sum_reg;
    assign done = done_reg;

endmodule

// ----- src/kli_serial_div.sv -----
// restoring divider, one quotient bit per cycle, truncating and saturating
`timescale 1ns / 1ps
module kli_serial_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [kli_pkg::KLI_W:0]          diff,
    input  logic [kli_pkg::STEP_W-1:0]              divisor,
    output logic signed [kli_pkg::KLI_W-1:0]        quotient,
    output logic                                    done
);
    import kli_pkg::*;

    localparam int NBITS = KLI_W + 1;
    localparam int CNTW  = $clog2(NBITS);

    logic [KLI_W:0]    dvd_reg;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] d_reg;
    logic              neg_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [KLI_W-1:0]  q_reg;

    logic [STEP_W:0]   rem_sh;
    logic              ge;
    logic [STEP_W:0]   rem_sub;
    logic [KLI_W:0]    q_full;
    logic [KLI_W:0]    mag;

    assign mag     = diff[KLI_W] ? (~diff + 1'b1) : diff;
    assign rem_sh  = {rem_reg, dvd_reg[KLI_W]};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};
    assign q_full  = {dvd_reg[KLI_W-1:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NBITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= mag;
            rem_reg <= '0;
            d_reg   <= divisor;
            neg_reg <= diff[KLI_W];
        end
        else if (run_reg)
        begin
            dvd_reg <= q_full;
            rem_reg <= ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
            if (cnt_reg == CNTW'(NBITS - 1))
            begin
                if (!neg_reg)
                    q_reg <= (q_full[KLI_W:KLI_W-1] != 2'b00) ? {1'b0, {(KLI_W-1){1'b1}}}
                                                            : q_full[KLI_W-1:0];
                else if (q_full[KLI_W] || (q_full[KLI_W-1] && (q_full[KLI_W-2:0] != '0)))
                    q_reg <= {1'b1, {(KLI_W-1){1'b0}}};
                else
                    q_reg <= ~q_full[KLI_W-1:0] + 1'b1;
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ----- src/keyframe_linear_interpolator.sv -----
// top level: keyframe store, pose and increment rings, per-channel sequencer
//
// usage
//   commands enter on start/command/value/last_channel and are taken when busy
//   is low. store writes one channel value of the keyframe being loaded;
//   toggle starts playback (two or more keyframes held) or stops it; tick
//   advances the pose and reports every channel.
//   store and a stopping toggle finish in the cycle they are taken.
//   a starting toggle loads keyframe 0 and works out each increment with a
//   bit-serial divider and emits no results.
//   a tick emits CHANNELS results, one per transfer marked by strobe, each
//   held one cycle. an adding tick runs the bit-serial adder for each
//   channel; a tick that moves to a new segment runs the serial divider
//   for each channel; a stopped tick, or one that ends playback, only
//   reports the pose. busy stays high until the last result has gone.
//   the receiver cannot stall; results are never held back.
//   step_count lives at apb byte address 0; the user must write it only
//   while idle; the block does not enforce it. reset clears pose, increments,
//   counters and playback; the keyframe store is undefined until written.
`timescale 1ns / 1ps
module keyframe_linear_interpolator #(
    parameter int CHANNELS = kli_pkg::DEF_CHANNELS,
    parameter int MAX_KEYS = kli_pkg::DEF_MAX_KEYS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    input  logic               last_channel,
    output logic               strobe,
    output logic [5:0]         channel,
    output logic signed [31:0] pose_value,
    output logic               last,
    output logic               playing,
    output logic [5:0]         segment,
    output logic [6:0]         frames_stored,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import kli_pkg::*;

    localparam int DEPTH = MAX_KEYS * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = $clog2(MAX_KEYS);
    localparam int FW    = $clog2(MAX_KEYS + 1);
    localparam int CMPW  = FW + 1;

    logic signed [KLI_W-1:0] mem [DEPTH];
    logic signed [KLI_W-1:0] rd_data_reg;

    logic signed [KLI_W-1:0] pose_ring [CHANNELS];
    logic signed [KLI_W-1:0] inc_ring  [CHANNELS];

    logic [STEP_W-1:0]   step_count_reg;
    logic [FW-1:0]       fc_reg;
    logic [CW-1:0]       load_ch_reg;
    logic [AW-1:0]       store_base_reg;
    logic                play_reg;
    logic [SW-1:0]       seg_reg;
    logic [AW-1:0]       seg_base_reg;
    logic [STEP_W-1:0]   step_cnt_reg;
    logic [CW-1:0]       ch_reg;
    kli_mode_t           mode_reg;
    logic                emit_reg;
    kli_state_t          state_reg;
    kli_state_t          state_next;
    logic signed [KLI_W-1:0] next_val_reg;
    logic signed [KLI_W-1:0] cur_val_reg;

    logic                strobe_reg;
    logic [5:0]          channel_reg;
    logic signed [KLI_W-1:0] pose_value_reg;
    logic                last_reg;
    logic                playing_reg;
    logic [5:0]          segment_reg;
    logic [6:0]          frames_reg;

    logic                accept;
    logic                cfg_wr;
    logic [STEP_W-1:0]   eff_steps;
    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       next_addr;
    logic [AW-1:0]       rd_addr;
    logic                rd_en;
    logic                wr_en;
    logic                div_start;
    logic                add_start;
    logic                div_done;
    logic                add_done;
    logic signed [KLI_W-1:0] div_q;
    logic signed [KLI_W-1:0] add_sum;
    logic signed [KLI_W:0]   diff;
    logic signed [KLI_W-1:0] new_pose;
    logic signed [KLI_W-1:0] new_inc;
    logic                last_ch;
    logic                start_play;
    logic                seg_wrap;
    logic [SW-1:0]       seg_inc;
    logic                begin_pass;
    kli_mode_t           pass_mode;
    kli_state_t          first_state;

    function automatic logic last_ch_load();
        return load_ch_reg == CW'(CHANNELS - 1);
    endfunction

    assign accept    = start && !busy;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign eff_steps = (step_count_reg == '0) ? STEP_W'(1) : step_count_reg;
    assign cur_addr  = seg_base_reg + AW'(ch_reg);
    assign next_addr = seg_base_reg + AW'(CHANNELS) + AW'(ch_reg);
    assign last_ch   = (ch_reg == CW'(CHANNELS - 1));
    assign wr_en     = accept && (command == CMD_STORE) && (fc_reg < FW'(MAX_KEYS));
    assign diff      = {next_val_reg[KLI_W-1], next_val_reg} - {rd_data_reg[KLI_W-1], rd_data_reg};
    assign start_play = !play_reg && (fc_reg > FW'(1));
    assign seg_inc   = seg_reg + 1'b1;
    // stop when the segment after this one has no end keyframe
    assign seg_wrap  = (CMPW'(seg_inc) + CMPW'(2)) > CMPW'(fc_reg);

    // decide the kind of channel pass a command starts
    always_comb
    begin
        begin_pass = 1'b0;
        pass_mode  = MODE_REPORT;
        if (accept && (command == CMD_TOGGLE) && start_play)
        begin
            begin_pass = 1'b1;
            pass_mode  = MODE_LOAD;
        end
        else if (accept && (command == CMD_TICK))
        begin
            begin_pass = 1'b1;
            if (!play_reg)
                pass_mode = MODE_REPORT;
            else if (step_cnt_reg >= eff_steps)
                pass_mode = seg_wrap ? MODE_REPORT : MODE_ADVANCE;
            else
                pass_mode = MODE_ADD;
        end
    end

    always_comb
    begin
        kli_mode_t m;
        m = begin_pass ? pass_mode : mode_reg;
        case (m)
            MODE_LOAD, MODE_ADVANCE: first_state = ST_RD_NEXT;
            MODE_ADD:                first_state = ST_ADD_GO;
            default:                 first_state = ST_WRITE;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (begin_pass) state_next = first_state;
            ST_RD_NEXT:  state_next = ST_RD_CUR;
            ST_RD_CUR:   state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_WRITE;
            ST_ADD_GO:   state_next = ST_ADD_WAIT;
            ST_ADD_WAIT: if (add_done) state_next = ST_WRITE;
            ST_WRITE:    state_next = last_ch ? ST_IDLE : first_state;
            default:     state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = cur_addr;
        div_start = 1'b0;
        add_start = 1'b0;
        case (state_reg)
            ST_RD_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = next_addr;
            end
            ST_RD_CUR:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_addr;
            end
            ST_DIV_GO: div_start = 1'b1;
            ST_ADD_GO: add_start = 1'b1;
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_LOAD:
            begin
                new_pose = cur_val_reg;
                new_inc  = div_q;
            end
            MODE_ADVANCE:
            begin
                new_pose = pose_ring[0];
                new_inc  = div_q;
            end
            MODE_ADD:
            begin
                new_pose = add_sum;
                new_inc  = inc_ring[0];
            end
            default:
            begin
                new_pose = pose_ring[0];
                new_inc  = inc_ring[0];
            end
        endcase
    end

    kli_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .diff     (diff),
        .divisor  (eff_steps),
        .quotient (div_q),
        .done     (div_done)
    );

    kli_serial_add u_add (
        .clk   (clk),
        .rst_n (rst_n),
        .start (add_start),
        .a     (pose_ring[0]),
        .b     (inc_ring[0]),
        .sum   (add_sum),
        .done  (add_done)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[store_base_reg + AW'(load_ch_reg)] <= value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD_CUR)
            next_val_reg <= rd_data_reg;
        if (state_reg == ST_DIV_GO)
            cur_val_reg <= rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_count_reg <= STEP_RESET;
            fc_reg         <= '0;
            load_ch_reg    <= '0;
            store_base_reg <= '0;
            play_reg       <= 1'b0;
            seg_reg        <= '0;
            seg_base_reg   <= '0;
            step_cnt_reg   <= '0;
            ch_reg         <= '0;
            mode_reg       <= MODE_REPORT;
            emit_reg       <= 1'b0;
            strobe_reg     <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pose_ring[i] <= '0;
                inc_ring[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= 1'b0;

            if (cfg_wr && !paddr[2])
                step_count_reg <= pwdata[STEP_W-1:0];

            if (wr_en)
            begin
                if (last_channel)
                begin
                    fc_reg         <= fc_reg + 1'b1;
                    load_ch_reg    <= '0;
                    store_base_reg <= store_base_reg + AW'(CHANNELS);
                end
                else if (!last_ch_load())
                    load_ch_reg <= load_ch_reg + 1'b1;
            end

            if (accept && (command == CMD_TOGGLE))
            begin
                if (start_play)
                begin
                    play_reg     <= 1'b1;
                    seg_reg      <= '0;
                    seg_base_reg <= '0;
                    step_cnt_reg <= '0;
                end
                else
                    play_reg <= 1'b0;
            end

            if (accept && (command == CMD_TICK) && play_reg)
            begin
                if (step_cnt_reg >= eff_steps)
                begin
                    if (seg_wrap)
                    begin
                        seg_reg      <= '0;
                        seg_base_reg <= '0;
                        play_reg     <= 1'b0;
                    end
                    else
                    begin
                        seg_reg      <= seg_inc;
                        seg_base_reg <= seg_base_reg + AW'(CHANNELS);
                        step_cnt_reg <= '0;
                    end
                end
                else
                    step_cnt_reg <= step_cnt_reg + 1'b1;
            end

            if (begin_pass)
            begin
                ch_reg   <= '0;
                mode_reg <= pass_mode;
                emit_reg <= (command == CMD_TICK);
            end

            if (state_reg == ST_WRITE)
            begin
                // rotate both rings by one channel
                for (int i = 0; i < CHANNELS - 1; i++)
                begin
                    pose_ring[i] <= pose_ring[i+1];
                    inc_ring[i]  <= inc_ring[i+1];
                end
                pose_ring[CHANNELS-1] <= new_pose;
                inc_ring[CHANNELS-1]  <= new_inc;
                ch_reg <= last_ch ? '0 : ch_reg + 1'b1;
                if (emit_reg)
                    strobe_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_WRITE) && emit_reg)
        begin
            channel_reg    <= 6'(ch_reg);
            pose_value_reg <= new_pose;
            last_reg       <= last_ch;
            playing_reg    <= play_reg;
            segment_reg    <= 6'(seg_reg);
            frames_reg     <= 7'(fc_reg);
        end
    end

    assign busy          = (state_reg != ST_IDLE) || strobe_reg;
    assign strobe        = strobe_reg;
    assign channel       = channel_reg;
    assign pose_value    = pose_value_reg;
    assign last          = last_reg;
    assign playing       = playing_reg;
    assign segment       = segment_reg;
    assign frames_stored = frames_reg;
    assign prdata        = paddr[2] ? 32'd0 : 32'(step_count_reg);
    assign pready        = 1'b1;

endmodule

// ----- src/kli_checker.sv -----
// port-level checks for the keyframe interpolator, bound to the top level
`timescale 1ns / 1ps
module kli_checker #(
    parameter int CHANNELS = kli_pkg::DEF_CHANNELS,
    parameter int MAX_KEYS = kli_pkg::DEF_MAX_KEYS
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  command,
    input logic        strobe,
    input logic [5:0]  channel,
    input logic        last,
    input logic [6:0]  frames_stored
);
    import kli_pkg::*;

    // a result only appears while the command is still in hand
    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> busy)
        else $error("result transfer outside a busy period");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> (channel == 6'(CHANNELS - 1)))
        else $error("last flag on wrong channel");

    // more channels still to come after a non-final result
    assert property (@(posedge clk) disable iff (!rst_n) (strobe && !last) |=> busy)
        else $error("pose run ended early");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_TICK)) |=> busy)
        else $error("tick taken without starting a pose run");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (frames_stored <= 7'(MAX_KEYS)))
        else $error("keyframe count beyond store size");

endmodule

bind keyframe_linear_interpolator kli_checker #(
    .CHANNELS (CHANNELS),
    .MAX_KEYS (MAX_KEYS)
) u_kli_checker (.*);
